// ===== rtl/coates_pileup_inversion_defines.svh =====
// Assertion macros shared by the queue and engine RTL files.
`ifndef COATES_PILEUP_INVERSION_DEFINES_SVH
`define COATES_PILEUP_INVERSION_DEFINES_SVH

`ifndef SYNTHESIS
// Flag a condition that must never hold.
`define CPI_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("assertion failed: never");
// Flag a consequence that must hold in the same cycle as its cause.
`define CPI_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
`else
`define CPI_ASSERT_NEVER(lbl, expr)
`define CPI_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ===== rtl/cpi_pkg.sv =====
`default_nettype none
package cpi_pkg;

   localparam int COUNT_BITS     = 32;
   localparam int RATE_FRAC_BITS = 27;
   localparam int ACC_FRAC       = 57;
   localparam int DIV_STEPS      = 60;
   localparam int SERIES_TERMS   = 40;
   localparam int RND_SHIFT      = ACC_FRAC - RATE_FRAC_BITS;

   localparam logic [63:0] LN2_Q57  = 64'hB17217F7D1CF79AB >> 7;
   localparam logic [63:0] RND_HALF = 64'd1 << (RND_SHIFT - 1);
   localparam logic [31:0] CNT_MASK = (COUNT_BITS >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << COUNT_BITS) - 64'd1);

   // queue depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_SAT    = 2'd1,
      ST_DOMAIN = 2'd2
   } status_type;

   typedef struct packed {
      logic [31:0] bin_count;
      logic        last_bin;
   } req_type;

   typedef struct packed {
      logic [31:0] rate;
      status_type  status;
      logic        last_result;
   } rsp_type;

   // one classified bin handed from front to engine
   typedef struct packed {
      logic [31:0] prior;
      logic [31:0] after;
      status_type  status;
      logic        last;
   } task_type;

endpackage
`default_nettype wire

// ===== rtl/cpi_front.sv =====
`default_nettype none
module cpi_front
   import cpi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   input  wire logic [31:0] csr_data,
   input  wire logic        accept,
   input  wire req_type     req_data,
   output task_type         task_out
);

   logic [31:0] shot_ff, shot_in;
   logic [31:0] cycles_ff, cycles_in;
   logic        first_ff, first_in;
   logic        sat_ff, sat_in;

   logic [31:0] cyc;
   logic [31:0] n;
   logic        sat;

   always_comb begin
      cyc = first_ff ? (shot_ff & CNT_MASK) : cycles_ff;
      sat = first_ff ? 1'b0 : sat_ff;
      n   = req_data.bin_count & CNT_MASK;

      shot_in   = csr_valid ? csr_data : shot_ff;
      cycles_in = cycles_ff;
      first_in  = first_ff;
      sat_in    = sat_ff;

      task_out.prior  = cyc;
      task_out.after  = cyc - n;
      task_out.last   = req_data.last_bin;
      task_out.status = ST_OK;

      if (sat) begin
         task_out.status = ST_SAT;
      end else if (cyc == 32'd0) begin
         task_out.status = ST_DOMAIN;
      end else if (n >= cyc) begin
         task_out.status = ST_SAT;
      end

      if (accept) begin
         // drop surviving cycles on saturation, otherwise advance
         if (!sat && cyc != 32'd0 && n >= cyc) begin
            cycles_in = 32'd0;
            sat_in    = 1'b1;
         end else if (!sat && cyc != 32'd0) begin
            cycles_in = cyc - n;
            sat_in    = 1'b0;
         end else begin
            cycles_in = cyc;
            sat_in    = sat;
         end
         if (req_data.last_bin) begin
            first_in = 1'b1;
            sat_in   = 1'b0;
         end else begin
            first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shot_ff   <= 32'd0;
         cycles_ff <= 32'd0;
         first_ff  <= 1'b1;
         sat_ff    <= 1'b0;
      end else begin
         shot_ff   <= shot_in;
         cycles_ff <= cycles_in;
         first_ff  <= first_in;
         sat_ff    <= sat_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/cpi_queue.sv =====
`default_nettype none
`include "coates_pileup_inversion_defines.svh"
module cpi_queue
   import cpi_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire task_type wr_data,
   input  wire logic pop,
   output logic      full,
   output logic      empty,
   output task_type  rd_data
);

   task_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     do_push, do_pop;

   assign full    = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= wr_data;
   end

   `CPI_ASSERT_NEVER(a_queue_count, count_ff > (QUEUE_PTR_W+1)'(QUEUE_DEPTH))

endmodule
`default_nettype wire

// ===== rtl/cpi_engine.sv =====
`default_nettype none
`include "coates_pileup_inversion_defines.svh"
module cpi_engine
   import cpi_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_empty,
   input  wire task_type q_data,
   output logic          q_pop,
   input  wire logic     rsp_pop,
   output logic          rsp_empty,
   output rsp_type       rsp_data
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_KSRCH = 6'b000010,
      S_FDIV  = 6'b000100,
      S_MUL   = 6'b001000,
      S_IDIV  = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

   state_type     state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;
   task_type      task_ff, task_in;
   logic [5:0]    k_ff, k_in;
   logic [63:0]   rem_ff, rem_in, den_ff, den_in, q_ff, q_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          div_t_ff, div_t_in;
   logic [63:0]   t2_ff, t2_in, p_ff, p_in, sum_ff, sum_in;
   logic [5:0]    j_ff, j_in;
   logic [63:0]   ma_ff, ma_in, mb_ff, mb_in, pp_ff, pp_in;
   logic [127:0]  macc_ff, macc_in;
   logic [2:0]    mcnt_ff, mcnt_in;
   logic          mul_p_ff, mul_p_in;
   logic [7:0]    irem_ff, irem_in;
   logic [63:0]   idvd_ff, idvd_in;

   logic [31:0]   kshift;
   logic [63:0]   dshift, diff, q_next;
   logic          qbit;
   logic [1:0]    pidx;
   logic [31:0]   pa, pb;
   logic [6:0]    psh;
   logic [127:0]  macc_sum;
   logic [63:0]   mres;
   logic [7:0]    idv, irsh;
   logic          ibit;
   logic [63:0]   iq;
   logic [63:0]   acc, rnd, rshift;

   always_comb begin
      kshift = task_ff.prior >> ({1'b0, k_ff} + 7'd1);
      dshift = {32'd0, task_ff.after} << k_ff;

      diff   = den_ff - rem_ff;
      qbit   = (rem_ff >= diff);
      q_next = {q_ff[62:0], qbit};

      pidx = mcnt_ff[2:1];
      pa   = pidx[1] ? ma_ff[63:32] : ma_ff[31:0];
      pb   = pidx[0] ? mb_ff[63:32] : mb_ff[31:0];
      unique case (pidx)
         2'd0:    psh = 7'd0;
         2'd3:    psh = 7'd64;
         default: psh = 7'd32;
      endcase
      macc_sum = macc_ff + ({64'd0, pp_ff} << psh);
      mres     = macc_sum[123:60];

      idv  = {1'b0, j_ff, 1'b1};
      irsh = {irem_ff[6:0], idvd_ff[63]};
      ibit = (irsh >= idv);
      iq   = {idvd_ff[62:0], ibit};

      acc    = 64'({58'd0, k_ff} * LN2_Q57) + (sum_ff >> 2);
      rnd    = acc + RND_HALF;
      rshift = rnd >> RND_SHIFT;
   end

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      task_in      = task_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      div_t_in     = div_t_ff;
      t2_in        = t2_ff;
      p_in         = p_ff;
      sum_in       = sum_ff;
      j_in         = j_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      pp_in        = pp_ff;
      macc_in      = macc_ff;
      mcnt_in      = mcnt_ff;
      mul_p_in     = mul_p_ff;
      irem_in      = irem_ff;
      idvd_in      = idvd_ff;
      q_pop        = 1'b0;

      if (rsp_pop && out_valid_ff) out_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty && !out_valid_ff) begin
               q_pop   = 1'b1;
               task_in = q_data;
               if (q_data.status != ST_OK) begin
                  out_in.rate        = 32'd0;
                  out_in.status      = q_data.status;
                  out_in.last_result = q_data.last;
                  out_valid_in       = 1'b1;
               end else begin
                  k_in     = 6'd0;
                  state_in = S_KSRCH;
               end
            end
         end
         S_KSRCH: begin
            if (k_ff < 6'd63 && kshift >= task_ff.after) begin
               k_in = k_ff + 6'd1;
            end else begin
               rem_in   = {32'd0, task_ff.prior} - dshift;
               den_in   = dshift;
               q_in     = 64'd0;
               cnt_in   = 6'd0;
               div_t_in = 1'b0;
               state_in = S_FDIV;
            end
         end
         S_FDIV: begin
            rem_in = qbit ? (rem_ff - diff) : {rem_ff[62:0], 1'b0};
            q_in   = q_next;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               cnt_in = 6'd0;
               if (!div_t_ff) begin
                  // second pass: t = f / (2 + f)
                  rem_in   = q_next;
                  den_in   = (64'd1 << 61) + q_next;
                  q_in     = 64'd0;
                  div_t_in = 1'b1;
               end else begin
                  p_in     = q_next;
                  sum_in   = q_next;
                  ma_in    = q_next;
                  mb_in    = q_next;
                  macc_in  = 128'd0;
                  mcnt_in  = 3'd0;
                  mul_p_in = 1'b0;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            mcnt_in = mcnt_ff + 3'd1;
            if (!mcnt_ff[0]) begin
               pp_in = {32'd0, pa} * {32'd0, pb};
            end else begin
               macc_in = macc_sum;
               if (mcnt_ff == 3'd7) begin
                  if (!mul_p_ff) begin
                     t2_in    = mres;
                     j_in     = 6'd1;
                     ma_in    = p_ff;
                     mb_in    = mres;
                     macc_in  = 128'd0;
                     mcnt_in  = 3'd0;
                     mul_p_in = 1'b1;
                  end else begin
                     p_in = mres;
                     if (mres == 64'd0) begin
                        state_in = S_FIN;
                     end else begin
                        idvd_in  = mres;
                        irem_in  = 8'd0;
                        cnt_in   = 6'd0;
                        state_in = S_IDIV;
                     end
                  end
               end
            end
         end
         S_IDIV: begin
            irem_in = ibit ? (irsh - idv) : irsh;
            idvd_in = iq;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               sum_in = sum_ff + iq;
               j_in   = j_ff + 6'd1;
               if (j_ff < 6'(SERIES_TERMS - 1)) begin
                  ma_in    = p_ff;
                  mb_in    = t2_ff;
                  macc_in  = 128'd0;
                  mcnt_in  = 3'd0;
                  state_in = S_MUL;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            out_in.rate        = (rshift > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rshift[31:0];
            out_in.status      = ST_OK;
            out_in.last_result = task_ff.last;
            out_valid_in       = 1'b1;
            state_in           = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      task_ff  <= task_in;
      k_ff     <= k_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      div_t_ff <= div_t_in;
      t2_ff    <= t2_in;
      p_ff     <= p_in;
      sum_ff   <= sum_in;
      j_ff     <= j_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      pp_ff    <= pp_in;
      macc_ff  <= macc_in;
      mcnt_ff  <= mcnt_in;
      mul_p_ff <= mul_p_in;
      irem_ff  <= irem_in;
      idvd_ff  <= idvd_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   `CPI_ASSERT_IMPL(a_err_rate_zero, out_valid_ff && out_ff.status != ST_OK, out_ff.rate == 32'd0)
   `CPI_ASSERT_IMPL(a_busy_out_free, state_ff != S_IDLE, !out_valid_ff)
   `CPI_ASSERT_IMPL(a_k_bound, state_ff == S_FDIV || state_ff == S_FIN, k_ff <= 6'd31)

endmodule
`default_nettype wire

// ===== rtl/coates_pileup_inversion.sv =====
// Coates pile-up correction. Histogram bins are pushed in order with last_bin
// on the final one; each bin yields one result, rate = ln(1 + n/after) in
// unsigned Q5.27 rounded to nearest, where after is the count of laser cycles
// still unfired once the bin is taken out. shot_count is sampled at the first
// bin of each histogram. Once no cycles survive, that bin and the rest of the
// histogram report saturated with rate 0; a shot count of zero reports domain
// error for the whole histogram. The front stage takes one bin per cycle while
// the queue is not full and tracks the surviving cycles; a two-entry queue
// feeds the log engine. An error or saturated bin is answered straight from
// the idle state. A computed bin runs a binary exponent search for k
// (0 to 31), two bit-serial 60-step divisions, a squaring on a shared 32x32
// multiplier, and for each of the T series terms (at most 39) one multiply
// and a 64-step divide by 2j+1. The engine takes no new bin until its last
// result has been popped, so sustained throughput is set by its sequencer.
`default_nettype none
module coates_pileup_inversion
   import cpi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire req_type     req_data,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   task_type task_w, q_rd;
   logic     q_full, q_empty, q_pop, accept;

   // the register is always writable
   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   // classify each bin and advance the surviving cycle count
   cpi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .accept    (accept),
      .req_data  (req_data),
      .task_out  (task_w)
   );

   // hold classified bins so the front can run ahead of the log engine until the queue fills
   cpi_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .wr_data (task_w),
      .pop     (q_pop),
      .full    (q_full),
      .empty   (q_empty),
      .rd_data (q_rd)
   );

   // evaluate the logarithm and hold the result until taken
   cpi_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rd),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== tb/coates_pileup_inversion_checker.sv =====
`default_nettype none
module coates_pileup_inversion_checker
   import cpi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic        req_full,
   input  wire req_type     req_data,
   input  wire logic        rsp_empty,
   input  wire logic        rsp_pop,
   input  wire rsp_type     rsp_data,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [31:0] csr_data,
   output int               pending,
   output int               errors
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] shots;
   logic [63:0] unfired;
   logic        first_bin;
   logic        saturated;
   rsp_type     expected_rsps[$];

   // (a*b) >> 60, truncated
   function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
   endfunction

   // floor(num * 2^60 / den) for num < den
   function automatic logic [63:0] div_q60(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [63:0] rem;
      q = 0;
      rem = num;
      for (int i = 0; i < DIV_STEPS; i++) begin
         q = q << 1;
         if (rem >= den - rem) begin
            rem = rem - (den - rem);
            q[0] = 1'b1;
         end else begin
            rem = rem << 1;
         end
      end
      return q;
   endfunction

   // ln(left/after) in Q5.27, rounded half up, clamped
   function automatic logic [31:0] coates_rate(logic [63:0] left, logic [63:0] after);
      int unsigned k;
      logic [63:0] d, f, t, t2, p, sum, acc;
      k = 0;
      while (k < 63 && (left >> (k + 1)) >= after) k++;
      d = after << k;
      f = div_q60(left - d, d);
      t = div_q60(f, (64'd1 << 61) + f);
      t2 = mul_q60(t, t);
      p = t;
      sum = t;
      for (int j = 1; j < SERIES_TERMS; j++) begin
         p = mul_q60(p, t2);
         if (p == 0) break;
         sum = sum + p / (2 * j + 1);
      end
      acc = 64'(k) * LN2_Q57 + (sum >> 2);
      acc = (acc + RND_HALF) >> RND_SHIFT;
      return (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type     want;
      logic [63:0] n;
      logic [63:0] after;
      if (reset) begin
         shots = 0;
         unfired = 0;
         first_bin = 1'b1;
         saturated = 1'b0;
         expected_rsps.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) shots = csr_data & CNT_MASK;
         if (req_push && !req_full) begin
            n = {32'd0, req_data.bin_count & CNT_MASK};
            want.rate = 0;
            want.status = ST_OK;
            want.last_result = req_data.last_bin;
            if (first_bin) begin
               unfired = {32'd0, shots};
               saturated = 1'b0;
            end
            if (saturated) begin
               want.status = ST_SAT;
            end else if (unfired == 0) begin
               want.status = ST_DOMAIN;
            end else if (n >= unfired) begin
               saturated = 1'b1;
               unfired = 0;
               want.status = ST_SAT;
            end else begin
               after = unfired - n;
               want.rate = coates_rate(unfired, after);
               unfired = after;
            end
            first_bin = req_data.last_bin;
            if (req_data.last_bin) saturated = 1'b0;
            expected_rsps.push_back(want);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected item", 64'(rsp_data), 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.rate != want.rate)
                  report_mismatch("rate", rsp_data.rate, want.rate);
               if (rsp_data.status != want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.last_result != want.last_result)
                  report_mismatch("last_result", rsp_data.last_result, want.last_result);
            end
         end
      end
      pending = expected_rsps.size();
   end
endmodule
`default_nettype wire

// ===== tb/coates_pileup_inversion_tb.sv =====
`default_nettype none
module coates_pileup_inversion_tb
   import cpi_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 40_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   req_type     req_data = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;
   int          pending;
   int          errors;

   // idling controls, changed by the stimulus process
   logic        tx_idle = 1'b0;
   logic        rx_stall = 1'b0;
   logic        rx_hold = 1'b0;
   int unsigned idle_pct = 81;
   logic [31:0] shot_now = 0;
   longint      cycles = 0;

   coates_pileup_inversion uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   coates_pileup_inversion_checker u_checker (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .pending(pending), .errors(errors)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run as failed once the cycle limit is passed.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: pop freely, stall at random, or hold off entirely.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !rx_hold && (!rx_stall || $urandom_range(99) >= idle_pct);
      end
   end

   // Offer one bin; return at the edge where it is taken.
   task automatic send_bin(logic [31:0] n, logic last);
      if (tx_idle) begin
         while ($urandom_range(99) < idle_pct) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
      end
      req_push <= 1'b1;
      req_data <= '{bin_count: n, last_bin: last};
      do @(posedge clock); while (req_full);
   endtask

   // Drop push and wait until every result has been drained.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Write the shot count; call only with the block idle.
   task automatic write_shots(logic [31:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shot_now = v;
   endtask

   // Pick a bin count: mostly a small share of the shots, some extremes.
   function automatic logic [31:0] pick_count();
      case ($urandom_range(9))
         0: return 0;
         1: return $urandom;
         2: return $urandom_range(3);
         3: return shot_now - $urandom_range(2);
         default: return $urandom_range(0, (shot_now >> 4) + 1);
      endcase
   endfunction

   task automatic random_phase(int items);
      for (int i = 0; i < items; i++)
         send_bin(pick_count(), ($urandom_range(7) == 0) || (i == items - 1));
   endtask

   logic [31:0] shot_list[8] = '{32'd1000, 32'd0, 32'd1, 32'hFFFF_FFFF,
                                 32'd65536, 32'd2, 32'd50, 32'd7_000_000};

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty bin, small bin, exact saturation, saturated tail.
      write_shots(32'd1000);
      send_bin(32'd0, 1'b0);
      send_bin(32'd1, 1'b0);
      send_bin(32'd999, 1'b0);
      send_bin(32'd0, 1'b0);
      send_bin(32'd5, 1'b1);
      // Rearmed histogram; rewrite mid-histogram takes effect at the next one.
      send_bin(32'd10, 1'b0);
      drain();
      write_shots(32'd0);
      send_bin(32'd20, 1'b1);
      send_bin(32'd0, 1'b0);
      send_bin(32'hFFFF_FFFF, 1'b1);
      drain();
      // Full-scale shots: largest rate, then overshoot.
      write_shots(32'hFFFF_FFFF);
      send_bin(32'hFFFF_FFFE, 1'b1);
      send_bin(32'hFFFF_FFFF, 1'b1);
      send_bin(32'h8000_0000, 1'b0);
      send_bin(32'h7FFF_FFFF, 1'b0);
      send_bin(32'd0, 1'b1);
      send_bin(32'h5555_5555, 1'b0);
      send_bin(32'hAAAA_AAAA, 1'b1);
      drain();
      write_shots(32'd1);
      send_bin(32'd0, 1'b0);
      send_bin(32'd1, 1'b0);
      send_bin(32'd0, 1'b1);
      drain();

      // Long receiver hold-off while bins keep coming, so the input stalls.
      write_shots(32'd100000);
      fork
         begin
            rx_hold <= 1'b1;
            repeat (3000) @(posedge clock);
            rx_hold <= 1'b0;
         end
         random_phase(40);
      join
      drain();

      // Random phases: rotate shot counts and idling styles.
      for (int ph = 0; ph < 16; ph++) begin
         tx_idle <= (ph % 4 == 1) || (ph % 4 == 3);
         rx_stall <= (ph % 4 == 2) || (ph % 4 == 3);
         idle_pct <= (ph % 4 == 3) ? 32 : 81;
         write_shots((ph >= 8 && ph % 2 == 0) ? $urandom : shot_list[ph % 8]);
         random_phase(100);
         drain();
      end

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire
